// ===== sv/jsu_pkg.sv =====
// Shared types, character constants and byte-building functions for the
// JSON string unescaper. No dependencies.
package jsu_pkg;

  localparam int unsigned MaxOut = 5;
  localparam int unsigned CntW   = 3;
  localparam int unsigned HeldN  = 3;

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] CtlBs    = 8'h08;
  localparam logic [7:0] CtlFf    = 8'h0C;
  localparam logic [7:0] CtlLf    = 8'h0A;
  localparam logic [7:0] CtlCr    = 8'h0D;
  localparam logic [7:0] CtlTab   = 8'h09;

  localparam logic [15:0] Max1Byte = 16'h007F;
  localparam logic [15:0] Max2Byte = 16'h07FF;
  localparam logic [7:0]  Lead2    = 8'hC0;
  localparam logic [7:0]  Lead3    = 8'hE0;
  localparam logic [7:0]  ContMark = 8'h80;
  localparam logic [5:0]  ContMask = 6'h3F;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_HEX   = 2'd2
  } mode_e;

  // Result bytes caused by one input item.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] data;
    logic [CntW-1:0]        cnt;
  } obuf_t;

  // One queue entry: the bytes plus the end-of-string mark.
  typedef struct packed {
    obuf_t bytes;
    logic  str_end;
  } cmd_t;

  function automatic obuf_t put_byte(obuf_t o, logic [7:0] b);
    obuf_t r;
    r = o;
    if (o.cnt < CntW'(MaxOut)) begin
      r.data[o.cnt] = b;
      r.cnt = o.cnt + CntW'(1);
    end
    return r;
  endfunction

  function automatic logic [3:0] hex_value(logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) v = b[3:0];
    else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) v = 4'(b[3:0] + 4'd9);
    return v;
  endfunction

  function automatic obuf_t put_escaped(obuf_t o, logic [7:0] b);
    obuf_t r;
    r = o;
    unique case (b)
      ChQuote:  r = put_byte(o, ChQuote);
      ChBslash: r = put_byte(o, ChBslash);
      ChSlash:  r = put_byte(o, ChSlash);
      ChLowB:   r = put_byte(o, CtlBs);
      ChLowF:   r = put_byte(o, CtlFf);
      ChLowN:   r = put_byte(o, CtlLf);
      ChLowR:   r = put_byte(o, CtlCr);
      ChLowT:   r = put_byte(o, CtlTab);
      default:  r = put_byte(put_byte(o, ChBslash), b);
    endcase
    return r;
  endfunction

  function automatic obuf_t put_utf8(obuf_t o, logic [15:0] code);
    obuf_t r;
    if (code <= Max1Byte) begin
      r = put_byte(o, code[7:0]);
    end else if (code <= Max2Byte) begin
      r = put_byte(o, Lead2 | {3'b000, code[10:6]});
      r = put_byte(r, ContMark | {2'b00, code[5:0] & ContMask});
    end else begin
      r = put_byte(o, Lead3 | {4'b0000, code[15:12]});
      r = put_byte(r, ContMark | {2'b00, code[11:6] & ContMask});
      r = put_byte(r, ContMark | {2'b00, code[5:0] & ContMask});
    end
    return r;
  endfunction

endpackage

// ===== sv/jsu_front.sv =====
// Front end: accepts raw bytes, tracks escape state and builds the result
// bytes of each item. Depends on jsu_pkg.
module jsu_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  input  logic          q_ready_i,
  output logic          q_push_o,
  output jsu_pkg::cmd_t q_cmd_o
);
  import jsu_pkg::*;

  mode_e       mode_q, mode_d;
  logic [1:0]  dc_q, dc_d;
  logic [15:0] acc_q, acc_d;
  logic [7:0]  held_q [HeldN];
  logic        held_we;
  logic [15:0] acc_n;
  logic [7:0]  seq [HeldN];
  logic [2:0]  seq_n;
  logic        esc;
  obuf_t       ob;
  logic        accept;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i & q_ready_i;
  assign acc_n      = {acc_q[11:0], hex_value(in_byte_i)};

  always_comb begin
    ob      = '0;
    mode_d  = mode_q;
    dc_d    = dc_q;
    acc_d   = acc_q;
    held_we = 1'b0;
    esc     = 1'b0;
    seq_n   = {1'b0, dc_q} + 3'd1;
    for (int i = 0; i < HeldN; i++) begin
      seq[i] = (2'(i) < dc_q) ? held_q[i] : in_byte_i;
    end
    unique case (mode_q)
      MODE_ESC: begin
        if (in_byte_i == ChLowU) begin
          if (in_last_i) begin
            ob = put_byte(put_byte(ob, ChBslash), ChLowU);
          end else begin
            mode_d = MODE_HEX;
            dc_d   = 2'd0;
            acc_d  = '0;
          end
        end else begin
          ob     = put_escaped(ob, in_byte_i);
          mode_d = MODE_PLAIN;
        end
      end
      MODE_HEX: begin
        if (dc_q == 2'd3) begin
          ob     = put_utf8(ob, acc_n);
          mode_d = MODE_PLAIN;
          dc_d   = 2'd0;
          acc_d  = '0;
        end else if (in_last_i) begin
          ob = put_byte(put_byte(ob, ChBslash), ChLowU);
          // replay held digits and the final byte; a \u here cannot complete
          for (int i = 0; i < HeldN; i++) begin
            if (3'(i) < seq_n) begin
              if (esc) begin
                if (seq[i] == ChLowU) ob = put_byte(put_byte(ob, ChBslash), ChLowU);
                else ob = put_escaped(ob, seq[i]);
                esc = 1'b0;
              end else if (seq[i] == ChBslash) begin
                esc = 1'b1;
              end else begin
                ob = put_byte(ob, seq[i]);
              end
            end
          end
          if (esc) ob = put_byte(ob, ChBslash);
        end else begin
          held_we = 1'b1;
          dc_d    = dc_q + 2'd1;
          acc_d   = acc_n;
        end
      end
      default: begin
        if (in_byte_i == ChBslash) begin
          if (in_last_i) ob = put_byte(ob, ChBslash);
          else mode_d = MODE_ESC;
        end else begin
          ob     = put_byte(ob, in_byte_i);
          mode_d = MODE_PLAIN;
        end
      end
    endcase
    if (in_last_i) begin
      mode_d = MODE_PLAIN;
      dc_d   = 2'd0;
      acc_d  = '0;
    end
  end

  assign q_push_o        = accept & (ob.cnt != '0);
  assign q_cmd_o.bytes   = ob;
  assign q_cmd_o.str_end = in_last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PLAIN;
      dc_q   <= 2'd0;
      acc_q  <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      dc_q   <= dc_d;
      acc_q  <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && held_we) held_q[dc_q] <= in_byte_i;
  end

endmodule

// ===== sv/jsu_fifo.sv =====
// Two-entry queue of result commands between front and back end.
// Depends on jsu_pkg.
module jsu_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jsu_pkg::cmd_t push_cmd_i,
  output logic          ready_o,
  input  logic          pop_i,
  output logic          valid_o,
  output jsu_pkg::cmd_t head_o
);
  import jsu_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d  = ~wr_q;
      cnt_d = cnt_d + 2'd1;
    end
    if (pop_i) begin
      rd_d  = ~rd_q;
      cnt_d = cnt_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_cmd_i;
  end

endmodule

// ===== sv/jsu_back.sv =====
// Back end: takes one command from the queue and sends its bytes one per
// cycle on the output stream while out_ready_i is high. Depends on jsu_pkg.
module jsu_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  jsu_pkg::cmd_t q_head_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          out_item_last_o,
  output logic          out_str_end_o
);
  import jsu_pkg::*;

  cmd_t            cur_q;
  logic            cur_valid_q, cur_valid_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            item_last;
  logic            fire;

  assign item_last       = (idx_q == cur_q.bytes.cnt - CntW'(1));
  assign fire            = cur_valid_q & out_ready_i;
  assign q_pop_o         = q_valid_i & (~cur_valid_q | (fire & item_last));
  assign out_valid_o     = cur_valid_q;
  assign out_byte_o      = cur_q.bytes.data[idx_q];
  assign out_item_last_o = item_last;
  assign out_str_end_o   = item_last & cur_q.str_end;

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    if (fire) begin
      if (item_last) cur_valid_d = 1'b0;
      else idx_d = idx_q + CntW'(1);
    end
    // load the next command as the current one drains
    if (q_pop_o) begin
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cur_q <= q_head_i;
  end

endmodule

// ===== sv/json_string_unescaper_core.sv =====
// JSON string unescaper top level: front end, command queue and back end.
// Depends on jsu_pkg, jsu_front, jsu_fifo and jsu_back.
//
// Input stream: one raw byte of an escaped JSON string per item, tlast on
// the final byte. Output stream: unescaped UTF-8 bytes; tuser marks the last
// byte caused by an input item, tlast the last byte of the string.
// An input item yields 0 to 5 output bytes (\u codes give 1 to 3, a cut-off
// \u at the end of a string replays its digits).
// The first byte of an item is written into the command queue on accept,
// then loaded into the back end's current-command register and presented.
// Throughput: while tready is high, the back end sends one output byte per
// cycle, input items are taken one per cycle while the two-entry command
// queue has room, and input only stalls while multi-byte expansions drain.
// Items that produce no bytes never enter the queue.
// Reset clears the decode state and empties the queue; held \u digits need
// no reset. When the receiver drops tready the current byte holds and the
// queue fills, then the input side stalls.
module json_string_unescaper_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tuser_o,   // [0] out_last_of_item
  output logic       m_axis_tlast_o
);
  import jsu_pkg::*;

  logic q_ready;
  logic q_push;
  cmd_t q_in;
  logic q_pop;
  logic q_valid;
  cmd_t q_head;

  jsu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .q_ready_i  (q_ready),
    .q_push_o   (q_push),
    .q_cmd_o    (q_in)
  );

  jsu_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_in),
    .ready_o    (q_ready),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  jsu_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .out_valid_o     (m_axis_tvalid_o),
    .out_ready_i     (m_axis_tready_i),
    .out_byte_o      (m_axis_tdata_o),
    .out_item_last_o (m_axis_tuser_o),
    .out_str_end_o   (m_axis_tlast_o)
  );

endmodule

// ===== tb/sv/jsu_unescape_checker.sv =====
`timescale 1ns / 1ps
// Checker for the JSON string unescaper: watches both stream channels, predicts
// the unescaped bytes of each accepted input item and compares them in order.
// Depends on jsu_pkg for the decode modes and character constants.
module jsu_unescape_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  logic        s_axis_tlast_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,   // [7:0] out_byte
  input  logic        m_axis_tuser_i,   // [0] out_last_of_item
  input  logic        m_axis_tlast_i,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned bytes_seen_o
);
  import jsu_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       item_end;
    logic       str_end;
  } text_byte_t;

  text_byte_t text_q[$];

  // Shadow of the decoder state.
  mode_e       dec_mode;
  logic [1:0]  ndig;
  logic [15:0] code;
  logic [7:0]  held [HeldN];

  logic [7:0]  emit_buf [MaxOut];
  int          emit_n;

  function automatic void queue_expected(text_byte_t t);
    text_q.insert(text_q.size(), t);
  endfunction

  function automatic void emit(logic [7:0] b);
    if (emit_n < MaxOut) begin
      emit_buf[emit_n] = b;
      emit_n++;
    end
  endfunction

  function automatic void emit_escaped(logic [7:0] b);
    case (b)
      ChQuote, ChBslash, ChSlash: emit(b);
      ChLowB: emit(CtlBs);
      ChLowF: emit(CtlFf);
      ChLowN: emit(CtlLf);
      ChLowR: emit(CtlCr);
      ChLowT: emit(CtlTab);
      default: begin
        emit(ChBslash);
        emit(b);
      end
    endcase
  endfunction

  task automatic unescape_byte(input logic [7:0] b, input logic last);
    logic [3:0]  nib;
    logic [15:0] acc;
    logic [7:0]  tail [HeldN+1];
    logic        esc;
    int          n;
    emit_n = 0;
    case (dec_mode)
      MODE_ESC: begin
        if (b == ChLowU) begin
          if (last) begin
            emit(ChBslash);
            emit(ChLowU);
          end else begin
            dec_mode = MODE_HEX;
            ndig = '0;
            code = '0;
          end
        end else begin
          emit_escaped(b);
          dec_mode = MODE_PLAIN;
        end
      end
      MODE_HEX: begin
        if (b >= "0" && b <= "9") nib = 4'(b - "0");
        else if (b >= "A" && b <= "F") nib = 4'(b - "A" + 10);
        else if (b >= "a" && b <= "f") nib = 4'(b - "a" + 10);
        else nib = 4'd0;
        acc = {code[11:0], nib};
        if (ndig == 2'd3) begin
          if (acc <= Max1Byte) begin
            emit(acc[7:0]);
          end else if (acc <= Max2Byte) begin
            emit(Lead2 | {3'b000, acc[10:6]});
            emit(ContMark | {2'b00, acc[5:0]});
          end else begin
            emit(Lead3 | {4'b0000, acc[15:12]});
            emit(ContMark | {2'b00, acc[11:6]});
            emit(ContMark | {2'b00, acc[5:0]});
          end
          dec_mode = MODE_PLAIN;
          ndig = '0;
          code = '0;
        end else if (last) begin
          // Cut-off code: give back "\u", then replay the digits as plain text.
          n = int'(ndig) + 1;
          for (int i = 0; i < int'(ndig); i++) tail[i] = held[i];
          tail[ndig] = b;
          emit(ChBslash);
          emit(ChLowU);
          esc = 1'b0;
          for (int i = 0; i < n; i++) begin
            if (esc) begin
              if (tail[i] == ChLowU) begin
                emit(ChBslash);
                emit(ChLowU);
              end else begin
                emit_escaped(tail[i]);
              end
              esc = 1'b0;
            end else if (tail[i] == ChBslash) begin
              esc = 1'b1;
            end else begin
              emit(tail[i]);
            end
          end
          if (esc) emit(ChBslash);
        end else begin
          held[ndig] = b;
          ndig = ndig + 2'd1;
          code = acc;
        end
      end
      default: begin
        if (b == ChBslash) begin
          if (last) emit(ChBslash);
          else dec_mode = MODE_ESC;
        end else begin
          emit(b);
          dec_mode = MODE_PLAIN;
        end
      end
    endcase
    if (last) begin
      dec_mode = MODE_PLAIN;
      ndig = '0;
      code = '0;
    end
    for (int k = 0; k < emit_n; k++) begin
      queue_expected('{data: emit_buf[k], item_end: (k == emit_n - 1),
                       str_end: (k == emit_n - 1) && last});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    text_byte_t want;
    if (!rst_ni) begin
      dec_mode = MODE_PLAIN;
      ndig = '0;
      code = '0;
      text_q.delete();
      errors_o = 0;
      pending_o = 0;
      bytes_seen_o = 0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        unescape_byte(s_axis_tdata_i, s_axis_tlast_i);
      end
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        bytes_seen_o++;
        if (text_q.size() == 0) begin
          errors_o++;
          $display("%0t: expected no byte, got %02h user %0b last %0b",
                   $time, m_axis_tdata_i, m_axis_tuser_i, m_axis_tlast_i);
        end else begin
          want = text_q.pop_front();
          if (m_axis_tdata_i !== want.data || m_axis_tuser_i !== want.item_end ||
              m_axis_tlast_i !== want.str_end) begin
            errors_o++;
            $display("%0t: expected %02h user %0b last %0b, got %02h user %0b last %0b",
                     $time, want.data, want.item_end, want.str_end,
                     m_axis_tdata_i, m_axis_tuser_i, m_axis_tlast_i);
          end
        end
      end
      pending_o = text_q.size();
    end
  end

endmodule

// ===== tb/sv/json_string_unescaper_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for json_string_unescaper_core: clock, reset, string stimulus
// under four handshake pressure phases and the final verdict.
// Depends on jsu_pkg, the core and jsu_unescape_checker.
module json_string_unescaper_core_tb;
  import jsu_pkg::*;

  localparam int unsigned RandItems  = 300;
  localparam int unsigned CycleLimit = 400000;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       s_valid = 1'b0;
  logic       s_ready;
  logic [7:0] s_data = 8'h00;
  logic       s_last = 1'b0;
  logic       m_valid;
  logic       m_ready = 1'b0;
  logic [7:0] m_data;
  logic       m_user;
  logic       m_last;

  int unsigned errors, pending, bytes_seen;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned rand_items = 0;
  int unsigned items_sent = 0;
  int unsigned strings_sent = 0;
  int unsigned cycle_cnt = 0;

  logic [7:0] str_q[$];

  json_string_unescaper_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user),
    .m_axis_tlast_o (m_last)
  );

  jsu_unescape_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_i(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tlast_i (s_last),
    .m_axis_tvalid_i(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_i (m_data),
    .m_axis_tuser_i (m_user),
    .m_axis_tlast_i (m_last),
    .errors_o       (errors),
    .pending_o      (pending),
    .bytes_seen_o   (bytes_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) m_ready <= ($urandom_range(0, 99) >= stall_pct);

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("timeout after %0d cycles with %0d bytes outstanding", cycle_cnt, pending);
      $display("json_string_unescaper_core verification failed");
      $finish;
    end
  end

  // Append one byte to the string under construction.
  function automatic void add_byte(logic [7:0] b);
    str_q.insert(str_q.size(), b);
  endfunction

  // Drive one item at the falling edge, with random idle cycles ahead of it.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= b;
    s_last  <= last;
    do @(posedge clk_i); while (!s_ready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_byte(txt[i], i == txt.len() - 1);
    strings_sent++;
  endtask

  // One random string: mostly well-formed escapes with random content, some noise.
  task automatic send_random_string();
    logic [15:0] val;
    logic [3:0]  nib;
    int          parts, kind, ndigits;
    str_q.delete();
    parts = $urandom_range(1, 6);
    for (int p = 0; p < parts; p++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        val[7:0] = 8'($urandom_range(8'h20, 8'h7E));
        add_byte(val[7:0] == ChBslash ? 8'h41 : val[7:0]);
      end else if (kind < 40) begin
        add_byte(8'($urandom_range(0, 255)));
      end else if (kind < 60) begin
        add_byte(ChBslash);
        case ($urandom_range(0, 8))
          0: add_byte(ChQuote);
          1: add_byte(ChBslash);
          2: add_byte(ChSlash);
          3: add_byte(ChLowB);
          4: add_byte(ChLowF);
          5: add_byte(ChLowN);
          6: add_byte(ChLowR);
          7: add_byte(ChLowT);
          default: add_byte(8'($urandom_range(0, 255)));
        endcase
      end else begin
        // Full code point, or a cut-off one that ends the string.
        ndigits = (kind < 85) ? 4 : $urandom_range(0, 3);
        case ($urandom_range(0, 2))
          0: val = 16'($urandom_range(0, 16'h007F));
          1: val = 16'($urandom_range(16'h0080, 16'h07FF));
          default: val = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        add_byte(ChBslash);
        add_byte(ChLowU);
        for (int d = 0; d < ndigits; d++) begin
          nib = val[15 - 4*d -: 4];
          if ($urandom_range(0, 9) == 0) add_byte(8'($urandom_range(0, 255)));
          else if (nib < 10) add_byte(8'("0") + 8'(nib));
          else if ($urandom_range(0, 1)) add_byte(8'("A") + 8'(nib) - 8'd10);
          else add_byte(8'("a") + 8'(nib) - 8'd10);
        end
        if (ndigits < 4) break;
      end
    end
    if ($urandom_range(0, 9) == 0) add_byte(ChBslash);
    for (int i = 0; i < str_q.size(); i++) begin
      // Pressure phase follows progress through the random part.
      case (rand_items * 4 / RandItems)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 35; stall_pct = 35; end
      endcase
      send_byte(str_q[i], i == str_q.size() - 1);
      rand_items++;
    end
    strings_sent++;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: byte extremes, code point sizes, odd escapes, cut-off codes.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    strings_sent += 2;
    send_text("\\uFFFF");
    send_text("\\u07fF\\q");
    send_text("\\t\\u");
    send_text("\\u1");
    send_text("\\u\\u");
    send_text("\\");

    while (rand_items < RandItems) send_random_string();
    s_valid <= 1'b0;
    stall_pct = 20;

    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("sent %0d strings (%0d items) through idle and stall phases",
             strings_sent, items_sent);
    $display("checked %0d output bytes", bytes_seen);
    if (errors == 0) begin
      $display("json_string_unescaper_core verification clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("json_string_unescaper_core verification failed");
    end
    $finish;
  end

endmodule
